### hw/rtl/svs_pkg.sv
// Shared types and constants for the sine voice with soft saturation.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package svs_pkg;

  localparam int FRAC_BITS = 21;
  localparam int IDX_SPAN  = 2048;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int SAT_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'd1;

  localparam logic [15:0] SAT_CAP = 16'd64881;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // shared multiplier operand widths
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 22;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // clipper divider widths
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 17;
  localparam int DIV_CW = $clog2(DIV_QW);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

### hw/rtl/svs_sine_rom.sv
// One-period sine ROM with registered read, contents built at elaboration.
// Depends on svs_pkg for the fixed-point series constants.
`timescale 1ns / 1ps
`default_nettype none

module svs_sine_rom
  import svs_pkg::*;
#(
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  output logic      [15:0]   q_r
);

  function automatic logic [15:0] sine_entry(input int unsigned i);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] mag;
    logic [1:0]  quad;
    t = (64'(i) << 32) / 64'(DEPTH);
    quad = t[31:30];
    r = {34'd0, t[29:0]};
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    h = Q30_ONE - x2 / 64'd110;
    h = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
    h = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
    h = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
    h = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
    s = (x * h) >> 30;
    mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? 16'(-mag) : 16'(mag);
  endfunction

  logic [15:0] rom_w [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g);
  end

  always_ff @(posedge clk) begin
    q_r <= rom_w[addr];
  end

endmodule

`default_nettype wire

### hw/rtl/svs_mul_unit.sv
// Shared signed multiplier with registered product.
// Depends on svs_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module svs_mul_unit
  import svs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_AW-1:0] a,
  input  wire logic signed [MUL_BW-1:0] b,
  output logic signed      [MUL_PW-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

### hw/rtl/svs_div_unit.sv
// Restoring divider for the soft clipper, one quotient bit per cycle.
// Depends on svs_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module svs_div_unit
  import svs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic      [DIV_QW-1:0] q_r,
  output div_status_t            status
);

  localparam int SW = DIV_DW + DIV_QW - 1;

  logic [DIV_NW-1:0] rem_r;
  logic [SW-1:0]     dsh_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  assign ge = SW'(rem_r) >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= SW'(den) << (DIV_QW - 1);
      cnt_r <= DIV_CW'(DIV_QW - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[DIV_NW-1:0];
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[DIV_QW-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

### hw/rtl/sine_voice_with_soft_saturation.sv
// Sine voice: interpolated table oscillator, soft clipper, gain, Q1.15 out.
// Steps: read, interpolate, form x, then with saturation on the clipper (numerator,
// denominator, divider start, divide wait), gain and output. A request is taken
// only in idle, after the last is through; the clipper divider resolves one
// quotient bit per cycle. Reset clears state, phase, config and output valid; the
// sine ROM is constant. Depends on svs_pkg, svs_sine_rom, svs_mul_unit, svs_div_unit.
`timescale 1ns / 1ps
`default_nettype none

module sine_voice_with_soft_saturation
  import svs_pkg::*;
#(
  parameter int TABLE_SIZE = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [19:0]          in_pitch_factor,
  input  wire logic [16:0]          in_gain,
  input  wire logic                 in_block_end,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [15:0]        out_left_sample,
  output logic signed [15:0]        out_right_sample,
  output logic                      out_block_last
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int IDX_STEPS = (TABLE_SIZE >= IDX_SPAN) ? 0 :
                             $clog2((IDX_SPAN + TABLE_SIZE - 1) / TABLE_SIZE);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDB    = 4'd1;
  localparam logic [3:0] S_INTERP = 4'd2;
  localparam logic [3:0] S_X      = 4'd3;
  localparam logic [3:0] S_NUM    = 4'd4;
  localparam logic [3:0] S_DEN    = 4'd5;
  localparam logic [3:0] S_DIVST  = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_GAIN   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  logic [31:0]        phase_r;
  logic [31:0]        phase_inc_r;
  logic [SAT_W-1:0]   sat_r;
  logic [19:0]        pitch_r;
  logic [16:0]        gain_r;
  logic               last_r;
  logic [AW-1:0]      idx_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [15:0]        a_r;
  logic signed [16:0] x_r;
  logic [DIV_NW-1:0]  num_r;
  logic               out_valid_r;
  logic [15:0]        out_sample_r;
  logic               out_last_r;

  logic [17:0]        idx_rem;
  logic [AW-1:0]      idx_w;
  logic [AW-1:0]      nxt_idx;
  logic [AW-1:0]      rom_addr;
  logic [15:0]        rom_q;
  logic [15:0]        sat_eff;
  logic [16:0]        ax;
  logic [16:0]        diff;
  logic [DIV_DW-1:0]  den_w;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic [DIV_QW-1:0]  div_q;
  div_status_t        div_st;
  logic [34:0]        gsum;
  logic signed [18:0] yv;
  logic [15:0]        y_sat;
  logic               accept;
  logic               slot_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = state_r == S_IDLE;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    idx_rem = 18'(phase_r[31:FRAC_BITS]);
    for (int k = IDX_STEPS - 1; k >= 0; k--) begin
      if (idx_rem >= (18'(TABLE_SIZE) << k)) begin
        idx_rem = idx_rem - (18'(TABLE_SIZE) << k);
      end
    end
  end

  assign idx_w    = idx_rem[AW-1:0];
  assign nxt_idx  = (idx_r == AW'(TABLE_SIZE - 1)) ? '0 : idx_r + 1'b1;
  assign rom_addr = (state_r == S_RDB) ? nxt_idx : idx_w;

  svs_sine_rom #(.DEPTH(TABLE_SIZE)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q_r  (rom_q)
  );

  assign sat_eff = sat_r[SAT_W-1] ? SAT_CAP : sat_r[15:0];
  assign ax      = x_r[16] ? 17'(-x_r) : 17'(x_r);
  assign diff    = {rom_q[15], rom_q} - {a_r[15], a_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RDB: begin
        mul_a = {1'b0, phase_inc_r};
        mul_b = {2'b0, pitch_r};
      end
      S_INTERP: begin
        mul_a = {{(MUL_AW-17){diff[16]}}, diff};
        mul_b = {1'b0, frac_r};
      end
      S_NUM: begin
        mul_a = {16'd0, 17'h10000 + {1'b0, sat_eff}};
        mul_b = {5'd0, ax};
      end
      S_DEN: begin
        mul_a = {17'd0, sat_eff};
        mul_b = {5'd0, ax};
      end
      S_GAIN, S_OUT: begin
        mul_a = {{(MUL_AW-17){x_r[16]}}, x_r};
        mul_b = {5'd0, gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  svs_mul_unit u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign den_w = {2'b0, 17'h10000 - {1'b0, sat_eff}, 15'd0} + {mul_p[32:0], 1'b0};

  svs_div_unit u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_DIVST),
    .num    (num_r),
    .den    (den_w),
    .q_r    (div_q),
    .status (div_st)
  );

  assign gsum = mul_p[34:0] + 35'd32768;
  assign yv   = $signed(gsum[34:16]);

  always_comb begin
    if (yv > 19'sd32767) begin
      y_sat = 16'h7fff;
    end else if (yv < -19'sd32768) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = yv[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_RDB;
      S_RDB:    state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_X;
      S_X:      state_nxt = S_GAIN;
      S_NUM:    state_nxt = S_DEN;
      S_DEN:    state_nxt = S_DIVST;
      S_DIVST:  state_nxt = S_DIV;
      S_DIV:    if (div_st.done) state_nxt = S_GAIN;
      S_GAIN:   state_nxt = S_OUT;
      S_OUT:    if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
    if (state_r == S_X && sat_r != '0) begin
      state_nxt = S_NUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      phase_inc_r <= '0;
      sat_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHASE_INC:  phase_inc_r <= cfg_wdata;
          REG_SATURATION: sat_r <= cfg_wdata[SAT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_INTERP) begin
        phase_r <= phase_r + mul_p[47:16];
      end
      if (state_r == S_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pitch_r <= in_pitch_factor;
      gain_r  <= in_gain;
      last_r  <= in_block_end;
      idx_r   <= idx_w;
      frac_r  <= phase_r[FRAC_BITS-1:0];
    end
    if (state_r == S_RDB) begin
      a_r <= rom_q;
    end
    if (state_r == S_X) begin
      x_r <= $signed({a_r[15], a_r} + mul_p[37:21]);
    end
    if (state_r == S_DEN) begin
      num_r <= {mul_p[32:0], 15'd0};
    end
    if (state_r == S_DIV && div_st.done) begin
      x_r <= x_r[16] ? $signed(-div_q) : $signed(div_q);
    end
    if (state_r == S_OUT && slot_free) begin
      out_sample_r <= y_sat;
      out_last_r   <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_sample_r;
  assign out_right_sample = out_sample_r;
  assign out_block_last   = out_last_r;

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !div_st.done) |=> state_r == S_DIV)
    else $error("left divide wait early");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider done outside divide wait");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INTERP && !cfg_we) |=> $stable(phase_r))
    else $error("phase moved outside advance step");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised without output step");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for sine_voice_with_soft_saturation.
// Drives random and directed requests through a bit-exact predictor and
// checks every stereo result in order; depends on svs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import svs_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASE_ITEMS   = 200;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } stereo_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [19:0]          in_pitch_factor;
  logic [16:0]          in_gain;
  logic                 in_block_end;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [15:0]   out_left_sample;
  logic signed [15:0]   out_right_sample;
  logic                 out_block_last;

  // predictor state
  logic signed [15:0] wave_rom [IDX_SPAN];
  logic [31:0]        tone_phase;
  logic [31:0]        step_reg;
  logic [16:0]        drive_reg;

  stereo_t pending_samples[$];
  int      mismatch_count;
  int      cycle_count;
  bit      idle_on;

  sine_voice_with_soft_saturation #(
    .TABLE_SIZE(IDX_SPAN)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pitch_factor (in_pitch_factor),
    .in_gain         (in_gain),
    .in_block_end    (in_block_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_sample (out_left_sample),
    .out_right_sample(out_right_sample),
    .out_block_last  (out_block_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("FAIL sine_voice_with_soft_saturation");
        $finish;
      end
    end
  end

  // Q30 Taylor series with quadrant folding
  function automatic logic signed [15:0] sine_point(input int unsigned i);
    logic [63:0] t, quad, r, x, x2, h, s, mag;
    t    = ((64'(i) << 32) / IDX_SPAN) & 64'hFFFF_FFFF;
    quad = t >> 30;
    r    = t & 64'h3FFF_FFFF;
    if (quad[0]) r = Q30_ONE - r;
    x   = (r * HALF_PI_Q30) >> 30;
    x2  = (x * x) >> 30;
    h   = Q30_ONE - x2 / 110;
    h   = Q30_ONE - ((x2 * h) >> 30) / 72;
    h   = Q30_ONE - ((x2 * h) >> 30) / 42;
    h   = Q30_ONE - ((x2 * h) >> 30) / 20;
    h   = Q30_ONE - ((x2 * h) >> 30) / 6;
    s   = (x * h) >> 30;
    mag = (s * 32767 + (64'd1 << 29)) >> 30;
    if (mag > 32767) mag = 32767;
    return (quad >= 2) ? -mag[15:0] : mag[15:0];
  endfunction

  function automatic stereo_t render_sample(input logic [19:0] pitch, input logic [16:0] gain,
                                            input logic last);
    logic [31:0]        idx, nxt;
    logic signed [63:0] a, b, frac, x, y;
    logic [63:0]        s_eff, ax, num, den, quo, adv;
    stereo_t            res;
    idx  = (tone_phase >> FRAC_BITS) % IDX_SPAN;
    nxt  = (idx + 1) % IDX_SPAN;
    frac = $signed({43'd0, tone_phase[FRAC_BITS-1:0]});
    a    = wave_rom[idx];
    b    = wave_rom[nxt];
    x    = a + (((b - a) * frac) >>> FRAC_BITS);
    adv  = ({32'd0, step_reg} * {44'd0, pitch}) >> 16;
    tone_phase = tone_phase + adv[31:0];
    if (drive_reg != 0) begin
      s_eff = (drive_reg >= 17'd65536) ? 64'(SAT_CAP) : 64'(drive_reg);
      ax    = (x < 0) ? -x : x;
      num   = (64'd65536 + s_eff) * ax * 64'd32768;
      den   = (64'd65536 - s_eff) * 64'd32768 + 64'd2 * s_eff * ax;
      quo   = num / den;
      x     = (x < 0) ? -$signed(quo) : $signed(quo);
    end
    y = (x * $signed({47'd0, gain}) + 64'sd32768) >>> 16;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    res.left  = y[15:0];
    res.right = y[15:0];
    res.last  = last;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result checker
  always @(posedge clk) begin
    stereo_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("[%0t] unexpected result L=%0d R=%0d last=%0b", $realtime,
                   out_left_sample, out_right_sample, out_block_last);
      end else begin
        exp_s = pending_samples.pop_front();
        if (out_left_sample !== exp_s.left || out_right_sample !== exp_s.right ||
            out_block_last !== exp_s.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("[%0t] mismatch: exp L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     $realtime, $signed(exp_s.left), $signed(exp_s.right), exp_s.last,
                     out_left_sample, out_right_sample, out_block_last);
        end
      end
    end
  end

  // result-side backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_request(input logic [19:0] pitch, input logic [16:0] gain,
                              input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_pitch_factor = pitch;
    in_gain         = gain;
    in_block_end    = last;
    do @(posedge clk); while (!in_ready);
    pending_samples.push_back(render_sample(pitch, gain, last));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_PHASE_INC) step_reg = data;
    else drive_reg = data[16:0];
  endtask

  task automatic test_reset_state();
    send_request(20'd65536, 17'd65536, 1'b1);
    send_request(20'hFFFFF, 17'h1FFFF, 1'b0);
  endtask

  // quarter-period steps hit zero, both peaks and gain saturation
  task automatic test_bypass_waveform();
    write_reg(REG_PHASE_INC, 32'd512 << FRAC_BITS);
    send_request(20'd65536, 17'd65536, 1'b0);
    send_request(20'd65536, 17'h1FFFF, 1'b0);
    send_request(20'd65536, 17'd0, 1'b0);
    send_request(20'd65536, 17'h1FFFF, 1'b0);
    send_request(20'd65536, 17'd65536, 1'b1);
    write_reg(REG_PHASE_INC, 32'h0015_5555);
    repeat (3) send_request(20'd65536, 17'd65536, 1'b0);
  endtask

  // largest step with zero, full and tiny pitch; phase wraps
  task automatic test_pitch_extremes();
    write_reg(REG_PHASE_INC, 32'hFFFF_FFFF);
    send_request(20'd0, 17'd65536, 1'b0);
    send_request(20'hFFFFF, 17'd65536, 1'b0);
    send_request(20'd1, 17'd65536, 1'b0);
    send_request(20'd65536, 17'd65536, 1'b1);
  endtask

  task automatic test_saturation_extremes();
    write_reg(REG_PHASE_INC, (32'd171 << FRAC_BITS) | 32'h0004_0321);
    // full drive, upper write bits set beyond the register
    write_reg(REG_SATURATION, 32'hABCE_0000 | 32'h0001_0000);
    send_request(20'd65536, 17'd65536, 1'b0);
    send_request(20'd65536, 17'd40000, 1'b0);
    send_request(20'd65536, 17'h1FFFF, 1'b1);
    write_reg(REG_SATURATION, 32'h0001_FFFF);
    send_request(20'd65536, 17'd65536, 1'b0);
    send_request(20'd98304, 17'd65536, 1'b0);
    write_reg(REG_SATURATION, 32'd1);
    send_request(20'd65536, 17'd65536, 1'b0);
    send_request(20'd65536, 17'h1FFFF, 1'b0);
    write_reg(REG_SATURATION, 32'd65535);
    send_request(20'd65536, 17'd65536, 1'b0);
    send_request(20'd32768, 17'd65536, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [31:0] inc;
    logic [16:0] sat;
    logic [19:0] pitch;
    logic [16:0] gain;
    int          r;
    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 4))
        0: inc = $urandom_range(0, 1 << 26);
        1: inc = $urandom;
        2: inc = $urandom_range(1 << 21, 64 << 21);
        3: inc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        default: inc = $urandom_range(0, 4096);
      endcase
      case (ph)
        0, 4: sat = 17'd0;
        1: sat = 17'd65536;
        2: sat = 17'($urandom_range(1, 65535));
        3: sat = 17'h1FFFF;
        5: sat = 17'($urandom_range(0, 131071));
        default: sat = 17'd65535;
      endcase
      write_reg(REG_PHASE_INC, inc);
      write_reg(REG_SATURATION, {15'd0, sat});
      idle_on = (ph != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_for_results();
        r = $urandom_range(0, 99);
        if (r < 40) pitch = 20'($urandom_range(57344, 73728));
        else if (r < 70) pitch = 20'($urandom_range(0, 1048575));
        else pitch = 20'($urandom_range(0, 131071));
        if ($urandom_range(0, 99) < 85) gain = 17'($urandom_range(0, 65536));
        else gain = 17'($urandom_range(0, 131071));
        send_request(pitch, gain, $urandom_range(0, 31) == 0);
      end
      idle_on = 1'b1;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_PHASE_INC;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_pitch_factor = '0;
    in_gain         = '0;
    in_block_end    = 1'b0;
    mismatch_count  = 0;
    idle_on         = 1'b1;
    tone_phase      = '0;
    step_reg        = '0;
    drive_reg       = '0;
    for (int i = 0; i < IDX_SPAN; i++) wave_rom[i] = sine_point(i);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_bypass_waveform();
    test_pitch_extremes();
    test_saturation_extremes();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("PASS sine_voice_with_soft_saturation");
    end else begin
      $display("FAIL sine_voice_with_soft_saturation");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/svs_pkg.sv
hw/rtl/svs_sine_rom.sv
hw/rtl/svs_mul_unit.sv
hw/rtl/svs_div_unit.sv
hw/rtl/sine_voice_with_soft_saturation.sv
tb/tb_top.sv
